// File: hdl/ddo_pkg.sv
// Shared types, constants and the arctangent table of the odometry core.
// Used by ddo_muldiv, ddo_cordic and diff_drive_odometry_core; no dependencies.
package ddo_pkg;

   localparam int ANGLE_BITS = 32;
   localparam int POS_BITS   = 48;

   // serial multiply / divide unit
   localparam int MD_W  = 64;
   localparam int MD_BW = 26;
   localparam int MD_CW = $clog2(MD_W);

   // CORDIC
   localparam int CORD_W     = 33;
   localparam int CORD_STEPS = 31;
   localparam int CORD_IW    = $clog2(CORD_STEPS);
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [CORD_W-1:0] QUARTER_TURN = 33'sh040000000;
   localparam logic signed [CORD_W-1:0] HALF_TURN = 33'sh080000000;

   localparam logic [MD_BW-1:0] OMEGA_BIN_K = 26'd10937044;
   localparam logic [MD_BW-1:0] OMEGA_Q16_K = 26'd4096000;
   localparam logic [MD_BW-1:0] POS_DIV     = 26'd31250000;
   localparam logic [24:0]      DT_MAX      = 25'd16777216;
   localparam logic [MD_W-1:0]  W_MAX       = 64'h0000_0040_0000_0000;
   localparam logic [MD_W-1:0]  ANG_POS_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic [MD_W-1:0]  ANG_NEG_MAX = 64'h0000_0000_8000_0000;
   localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   localparam logic [1:0] FUNC_LEFT  = 2'd0;
   localparam logic [1:0] FUNC_RIGHT = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic CSR_WHEEL_BASE = 1'b0;
   localparam logic CSR_WATCHDOG   = 1'b1;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [23:0] wheel_speed;
      logic [47:0]        now_us;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic signed [31:0] heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [23:0] lin_vel;
      logic signed [31:0] ang_vel;
      logic               stopped;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic             divide;
      logic [MD_W-1:0]  a;
      logic [MD_BW-1:0] b;
   } md_cmd_type;

   function automatic logic [29:0] atan_step(input logic [CORD_IW-1:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'h20000000;
         5'd1:  r = 30'h12E4051E;
         5'd2:  r = 30'h09FB385B;
         5'd3:  r = 30'h051111D4;
         5'd4:  r = 30'h028B0D43;
         5'd5:  r = 30'h0145D7E1;
         5'd6:  r = 30'h00A2F61E;
         5'd7:  r = 30'h00517C55;
         5'd8:  r = 30'h0028BE53;
         5'd9:  r = 30'h00145F2F;
         5'd10: r = 30'h000A2F98;
         5'd11: r = 30'h000517CC;
         5'd12: r = 30'h00028BE6;
         5'd13: r = 30'h000145F3;
         5'd14: r = 30'h0000A2FA;
         5'd15: r = 30'h0000517D;
         5'd16: r = 30'h000028BE;
         5'd17: r = 30'h0000145F;
         5'd18: r = 30'h00000A30;
         5'd19: r = 30'h00000518;
         5'd20: r = 30'h0000028C;
         5'd21: r = 30'h00000146;
         5'd22: r = 30'h000000A3;
         5'd23: r = 30'h00000051;
         5'd24: r = 30'h00000029;
         5'd25: r = 30'h00000014;
         5'd26: r = 30'h0000000A;
         5'd27: r = 30'h00000005;
         5'd28: r = 30'h00000003;
         5'd29: r = 30'h00000001;
         5'd30: r = 30'h00000001;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/diff_drive_odometry_core.sv
// Differential-drive odometry core: speed updates, watchdog and midpoint pose integration.
// Depends on ddo_pkg, ddo_muldiv and ddo_cordic.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data): func 0 or 1 sets the left or right
//    wheel speed, func 2 requests an odometry tick, func 3 is dropped. Every request
//    carries now_us. A speed request does not stall; a tick request holds req_stall
//    high while the bit-serial multiply/divide unit runs 6 multiplies and 4 divides
//    and the CORDIC unit runs twice, and then until the response is loaded into the
//    free output register. Those two shared units set the tick latency.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data): one response per tick, taken from
//    an output register, so the core accepts new requests while a response waits.
//    A finished tick waits in its last state only if the previous response has not
//    yet been taken; rsp_stall never disturbs a held response.
//  - csr channel (csr_valid / csr_ready / csr_index / csr_wdata): index 0 is the wheel
//    base in micrometers, index 1 the watchdog timeout in microseconds. csr_ready is
//    always high; write only while the core is idle.
//  - reset (synchronous): pose, speeds and timestamps clear, the registers return to
//    a 166000 um base and a 500000 us timeout, no response is pending.
module diff_drive_odometry_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ddo_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ddo_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [26:0]       csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_W_MUL, S_W_DIV, S_D_MUL, S_CORD1, S_SD_MUL, S_X_MUL, S_X_DIV,
      S_Y_MUL, S_Y_DIV, S_A_MUL, S_A_DIV, S_CORD2, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [19:0] wheel_base_ff;
   logic [26:0] watchdog_ff;

   // odometry state
   logic [ddo_pkg::POS_BITS-1:0] x_acc_ff, y_acc_ff;
   logic [31:0]                  theta_ff;
   logic signed [23:0]           left_ff, right_ff;
   logic [47:0]                  last_tick_ff, last_speed_ff;

   // per-tick work registers
   logic                         launched_ff;
   logic                         stop_ff;
   logic [24:0]                  dt_ff;
   logic [ddo_pkg::MD_W-1:0]     prod_ff;
   logic [ddo_pkg::MD_W-1:0]     sumdt_ff;
   logic [38:0]                  w_mag_ff;
   logic signed [32:0]           delta_ff;
   logic signed [16:0]           c14_ff, s14_ff;
   logic signed [31:0]           ang_ff;
   logic signed [15:0]           qz_ff, qw_ff;

   logic                         rsp_valid_ff;
   ddo_pkg::rsp_type             rsp_data_ff;

   // shared units
   ddo_pkg::md_cmd_type          md_cmd;
   logic                         md_done;
   logic [ddo_pkg::MD_W-1:0]     md_result;
   logic                         cord_start, cord_done;
   logic [31:0]                  cord_angle;
   logic signed [ddo_pkg::CORD_W-1:0] cord_sin, cord_cos;

   // combinational helpers
   logic signed [24:0]           sum, diff;
   logic [24:0]                  sum_mag, diff_mag;
   logic [19:0]                  wb_eff;
   logic [47:0]                  dt_raw, idle_us;
   logic                         is_md, is_cord, unit_done;
   logic [31:0]                  theta_in;
   logic signed [ddo_pkg::MD_W-1:0] q_signed;
   logic [15:0]                  c14_mag, s14_mag;
   logic                         x_neg, y_neg;

   assign sum      = 25'(left_ff) + 25'(right_ff);
   assign diff     = 25'(right_ff) - 25'(left_ff);
   assign sum_mag  = sum[24] ? 25'(-sum) : 25'(sum);
   assign diff_mag = diff[24] ? 25'(-diff) : 25'(diff);
   assign wb_eff   = (wheel_base_ff == '0) ? 20'd1 : wheel_base_ff;
   assign dt_raw   = req_data.now_us - last_tick_ff;
   assign idle_us  = req_data.now_us - last_speed_ff;
   assign theta_in = (theta_ff + 32'(delta_ff)) & ddo_pkg::ANGLE_MASK;
   assign c14_mag  = c14_ff[16] ? 16'(-c14_ff) : 16'(c14_ff);
   assign s14_mag  = s14_ff[16] ? 16'(-s14_ff) : 16'(s14_ff);
   assign x_neg    = sum[24] ^ c14_ff[16];
   assign y_neg    = sum[24] ^ s14_ff[16];

   function automatic logic signed [15:0] q15(input logic signed [32:0] v);
      logic signed [34:0] t;
      t = (35'(v) + 35'sd16384) >>> 15;
      if (t > 35'sd32767) return 16'sh7FFF;
      if (t < -35'sd32768) return 16'sh8000;
      return 16'(t);
   endfunction

   // operand selection for the shared units
   always_comb begin
      is_md      = 1'b1;
      is_cord    = 1'b0;
      md_cmd     = '0;
      cord_angle = theta_ff + 32'(delta_ff >>> 1);
      case (state_ff)
         S_W_MUL: begin
            md_cmd.a = ddo_pkg::MD_W'(diff_mag);
            md_cmd.b = ddo_pkg::OMEGA_BIN_K;
         end
         S_W_DIV, S_A_DIV: begin
            md_cmd.divide = 1'b1;
            md_cmd.a      = prod_ff;
            md_cmd.b      = ddo_pkg::MD_BW'(wb_eff);
         end
         S_D_MUL: begin
            md_cmd.a = ddo_pkg::MD_W'(w_mag_ff);
            md_cmd.b = ddo_pkg::MD_BW'(dt_ff);
         end
         S_SD_MUL: begin
            md_cmd.a = ddo_pkg::MD_W'(sum_mag);
            md_cmd.b = ddo_pkg::MD_BW'(dt_ff);
         end
         S_X_MUL: begin
            md_cmd.a = sumdt_ff;
            md_cmd.b = ddo_pkg::MD_BW'(c14_mag);
         end
         S_Y_MUL: begin
            md_cmd.a = sumdt_ff;
            md_cmd.b = ddo_pkg::MD_BW'(s14_mag);
         end
         S_X_DIV, S_Y_DIV: begin
            md_cmd.divide = 1'b1;
            md_cmd.a      = prod_ff;
            md_cmd.b      = ddo_pkg::POS_DIV;
         end
         S_A_MUL: begin
            md_cmd.a = ddo_pkg::MD_W'(diff_mag);
            md_cmd.b = ddo_pkg::OMEGA_Q16_K;
         end
         S_CORD1: begin
            is_md   = 1'b0;
            is_cord = 1'b1;
         end
         S_CORD2: begin
            is_md      = 1'b0;
            is_cord    = 1'b1;
            // half heading, arithmetic shift of the signed angle
            cord_angle = {theta_ff[31], theta_ff[31:1]};
         end
         default: begin
            is_md = 1'b0;
         end
      endcase
      md_cmd.start = is_md && !launched_ff;
      cord_start   = is_cord && !launched_ff;
      unit_done    = is_md ? md_done : cord_done;
   end

   // sign of the finished product or quotient follows the operand signs of each step
   always_comb begin
      case (state_ff)
         S_X_DIV: q_signed = x_neg ? -$signed(md_result) : $signed(md_result);
         S_Y_DIV: q_signed = y_neg ? -$signed(md_result) : $signed(md_result);
         default: q_signed = diff[24] ? -$signed(md_result) : $signed(md_result);
      endcase
   end

   ddo_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .done   (md_done),
      .result (md_result)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .done    (cord_done),
      .sin_q30 (cord_sin),
      .cos_q30 (cord_cos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launched_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wheel_base_ff <= 20'd166000;
         watchdog_ff   <= 27'd500000;
         x_acc_ff      <= '0;
         y_acc_ff      <= '0;
         theta_ff      <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         last_tick_ff  <= '0;
         last_speed_ff <= '0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               ddo_pkg::CSR_WHEEL_BASE: wheel_base_ff <= csr_wdata[19:0];
               ddo_pkg::CSR_WATCHDOG:   watchdog_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // drop a response once taken, unless a new one loads this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         // launch a shared unit, then wait for its done pulse
         if ((is_md || is_cord) && !launched_ff) launched_ff <= 1'b1;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (req_data.func)
                     ddo_pkg::FUNC_LEFT: begin
                        left_ff       <= req_data.wheel_speed;
                        last_speed_ff <= req_data.now_us;
                     end
                     ddo_pkg::FUNC_RIGHT: begin
                        right_ff      <= req_data.wheel_speed;
                        last_speed_ff <= req_data.now_us;
                     end
                     ddo_pkg::FUNC_TICK: begin
                        dt_ff        <= (dt_raw > 48'(ddo_pkg::DT_MAX)) ? ddo_pkg::DT_MAX
                                                                     : dt_raw[24:0];
                        last_tick_ff <= req_data.now_us;
                        // watchdog: zero both speeds on a stale update
                        stop_ff      <= idle_us > 48'(watchdog_ff);
                        if (idle_us > 48'(watchdog_ff)) begin
                           left_ff  <= '0;
                           right_ff <= '0;
                        end
                        state_ff <= S_W_MUL;
                     end
                     default: ;
                  endcase
               end
            end

            S_DONE: begin
               // load the output register once it is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_data_ff.pos_x   <= 48'($signed(x_acc_ff));
                  rsp_data_ff.pos_y   <= 48'($signed(y_acc_ff));
                  rsp_data_ff.heading <= $signed(theta_ff);
                  rsp_data_ff.quat_z  <= qz_ff;
                  rsp_data_ff.quat_w  <= qw_ff;
                  rsp_data_ff.lin_vel <= 24'(sum >>> 1);
                  rsp_data_ff.ang_vel <= ang_ff;
                  rsp_data_ff.stopped <= stop_ff;
                  state_ff            <= S_IDLE;
               end
            end

            default: begin
               if (launched_ff && unit_done) begin
                  launched_ff <= 1'b0;
                  case (state_ff)
                     S_W_MUL: begin
                        prod_ff  <= md_result;
                        state_ff <= S_W_DIV;
                     end
                     S_W_DIV: begin
                        // clamp the turn rate magnitude at 2^38
                        w_mag_ff <= (md_result > ddo_pkg::W_MAX) ? 39'(ddo_pkg::W_MAX)
                                                                  : md_result[38:0];
                        state_ff <= S_D_MUL;
                     end
                     S_D_MUL: begin
                        delta_ff <= 33'(q_signed >>> 8);
                        state_ff <= S_CORD1;
                     end
                     S_CORD1: begin
                        c14_ff   <= 17'((34'(cord_cos) + 34'sd32768) >>> 16);
                        s14_ff   <= 17'((34'(cord_sin) + 34'sd32768) >>> 16);
                        theta_ff <= theta_in;
                        state_ff <= S_SD_MUL;
                     end
                     S_SD_MUL: begin
                        sumdt_ff <= md_result;
                        state_ff <= S_X_MUL;
                     end
                     S_X_MUL: begin
                        prod_ff  <= md_result;
                        state_ff <= S_X_DIV;
                     end
                     S_X_DIV: begin
                        x_acc_ff <= x_acc_ff + ddo_pkg::POS_BITS'(q_signed);
                        state_ff <= S_Y_MUL;
                     end
                     S_Y_MUL: begin
                        prod_ff  <= md_result;
                        state_ff <= S_Y_DIV;
                     end
                     S_Y_DIV: begin
                        y_acc_ff <= y_acc_ff + ddo_pkg::POS_BITS'(q_signed);
                        state_ff <= S_A_MUL;
                     end
                     S_A_MUL: begin
                        prod_ff  <= md_result;
                        state_ff <= S_A_DIV;
                     end
                     S_A_DIV: begin
                        // saturate the angular rate to 32 bits
                        if (!diff[24] && md_result > ddo_pkg::ANG_POS_MAX)
                           ang_ff <= 32'sh7FFF_FFFF;
                        else if (diff[24] && md_result > ddo_pkg::ANG_NEG_MAX)
                           ang_ff <= 32'sh8000_0000;
                        else
                           ang_ff <= 32'(q_signed);
                        state_ff <= S_CORD2;
                     end
                     S_CORD2: begin
                        qz_ff    <= q15(cord_sin);
                        qw_ff    <= q15(cord_cos);
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // the multiply/divide unit never reports done in the cycle right after its launch
   a_md_not_instant: assert property (@(posedge clock) disable iff (reset)
      md_cmd.start |=> !md_done) else $error("muldiv done right after start");

   // done pulses come only from a launched unit
   a_md_launched: assert property (@(posedge clock) disable iff (reset)
      md_done |-> launched_ff) else $error("muldiv done without launch");

   a_cord_launched: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> launched_ff) else $error("cordic done without launch");

   // a new response is only loaded when the old one is gone or taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> rsp_valid_ff
         && $stable(rsp_data_ff)) else $error("response overwritten");

endmodule

// File: hdl/ddo_muldiv.sv
// Bit-serial unsigned multiplier (shift-add) and restoring divider.
// Depends on ddo_pkg for widths and the command struct.
module ddo_muldiv (
   input  logic                          clock,
   input  logic                          reset,
   input  ddo_pkg::md_cmd_type           cmd,
   output logic                          done,
   output logic [ddo_pkg::MD_W-1:0]      result
);

   logic                          running_ff;
   logic                          div_ff;
   logic                          done_ff;
   logic [ddo_pkg::MD_CW-1:0]     cnt_ff;
   logic [ddo_pkg::MD_W-1:0]      acc_ff;
   logic [ddo_pkg::MD_W-1:0]      a_ff;
   logic [ddo_pkg::MD_BW-1:0]     b_ff;
   logic [ddo_pkg::MD_BW:0]       rem_ff;
   logic [ddo_pkg::MD_BW:0]       rem_sh;
   logic                          fits;

   assign rem_sh = {rem_ff[ddo_pkg::MD_BW-1:0], acc_ff[ddo_pkg::MD_W-1]};
   assign fits   = rem_sh >= {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            running_ff <= 1'b1;
            div_ff     <= cmd.divide;
            cnt_ff     <= cmd.divide ? ddo_pkg::MD_CW'(ddo_pkg::MD_W - 1)
                                     : ddo_pkg::MD_CW'(ddo_pkg::MD_BW - 1);
            acc_ff     <= cmd.divide ? cmd.a : '0;
            a_ff       <= cmd.a;
            b_ff       <= cmd.b;
            rem_ff     <= '0;
         end else if (running_ff) begin
            if (div_ff) begin
               // one quotient bit per cycle
               rem_ff <= fits ? rem_sh - {1'b0, b_ff} : rem_sh;
               acc_ff <= {acc_ff[ddo_pkg::MD_W-2:0], fits};
            end else begin
               // one multiplier bit per cycle
               if (b_ff[0]) acc_ff <= acc_ff + a_ff;
               a_ff <= {a_ff[ddo_pkg::MD_W-2:0], 1'b0};
               b_ff <= {1'b0, b_ff[ddo_pkg::MD_BW-1:1]};
            end
            if (cnt_ff == '0) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// File: hdl/ddo_cordic.sv
// Iterative CORDIC: sine and cosine of a 32-bit binary angle in Q30, one step a cycle.
// Depends on ddo_pkg for the arctangent table and the gain constant.
module ddo_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         angle,
   output logic                                done,
   output logic signed [ddo_pkg::CORD_W-1:0]   sin_q30,
   output logic signed [ddo_pkg::CORD_W-1:0]   cos_q30
);

   logic                                running_ff;
   logic                                done_ff;
   logic                                flip_ff;
   logic [ddo_pkg::CORD_IW-1:0]         i_ff;
   logic signed [ddo_pkg::CORD_W-1:0]   x_ff, y_ff, z_ff;
   logic signed [ddo_pkg::CORD_W-1:0]   sin_ff, cos_ff;
   logic signed [ddo_pkg::CORD_W-1:0]   z_start, x_sh, y_sh, at, x_in, y_in, z_in;

   assign z_start = ddo_pkg::CORD_W'($signed(angle));
   assign x_sh    = y_ff >>> i_ff;
   assign y_sh    = x_ff >>> i_ff;
   assign at      = ddo_pkg::CORD_W'($signed({1'b0, ddo_pkg::atan_step(i_ff)}));
   assign x_in    = z_ff[ddo_pkg::CORD_W-1] ? x_ff + x_sh : x_ff - x_sh;
   assign y_in    = z_ff[ddo_pkg::CORD_W-1] ? y_ff - y_sh : y_ff + y_sh;
   assign z_in    = z_ff[ddo_pkg::CORD_W-1] ? z_ff + at : z_ff - at;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            i_ff       <= '0;
            x_ff       <= ddo_pkg::CORDIC_GAIN;
            y_ff       <= '0;
            // fold the outer half-plane onto the inner one
            if (z_start > ddo_pkg::QUARTER_TURN) begin
               z_ff    <= z_start - ddo_pkg::HALF_TURN;
               flip_ff <= 1'b1;
            end else if (z_start < -ddo_pkg::QUARTER_TURN) begin
               z_ff    <= z_start + ddo_pkg::HALF_TURN;
               flip_ff <= 1'b1;
            end else begin
               z_ff    <= z_start;
               flip_ff <= 1'b0;
            end
         end else if (running_ff) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            i_ff <= i_ff + 1'b1;
            if (i_ff == ddo_pkg::CORD_IW'(ddo_pkg::CORD_STEPS - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
               sin_ff     <= flip_ff ? -y_in : y_in;
               cos_ff     <= flip_ff ? -x_in : x_in;
            end
         end
      end
   end

   assign done    = done_ff;
   assign sin_q30 = sin_ff;
   assign cos_q30 = cos_ff;

endmodule
